// ===== sv/khuc_pkg.sv =====
// ----------------------------------------------------------------------------
// khuc_pkg
// Types and constants shared by the key hash unlock check block.
// ----------------------------------------------------------------------------
package khuc_pkg;

  // Request coming in: one key byte or the lock command
  typedef struct packed {
    logic       op;
    logic [7:0] key_byte;
    logic       last;
  } khuc_in_t;

  // Result going out
  typedef struct packed {
    logic        matched;
    logic        locked_now;
    logic [31:0] hash_value;
  } khuc_out_t;

  // Finished key or lock command, from the hash stage to the lock stage
  typedef struct packed {
    logic        is_lock;
    logic [31:0] hash;
  } khuc_fin_t;

  localparam logic OP_KEY_BYTE = 1'b0;
  localparam logic OP_LOCK     = 1'b1;

  localparam logic [1:0] KIND_AP = 2'd0;
  localparam logic [1:0] KIND_BP = 2'd1;
  localparam logic [1:0] KIND_MX = 2'd2;

  localparam logic [31:0] AP_SEED   = 32'hAAAA_AAAA;
  localparam logic [31:0] MX_FACTOR = 32'h811C_9DC5;

  localparam logic [7:0] AP_CHAR_LO = 8'h30;  // '0'
  localparam logic [7:0] AP_CHAR_HI = 8'h4D;  // 'M'
  localparam logic [7:0] BP_CHAR_HI = 8'h6D;  // 'm'

endpackage

// ===== sv/key_hash_unlock_check.sv =====
// ----------------------------------------------------------------------------
// key_hash_unlock_check
// Hashes a key byte by byte and unlocks when the hash equals a set value.
// ----------------------------------------------------------------------------
// One request enters per clock cycle unless in_stall_o holds it; the running
// hash absorbs a byte per cycle through one 32x32 constant multiply or a few
// shifts and xors. A request passes an input register, the hash stage and the
// lock stage, each registering it in turn. Only a final key byte or a lock
// command produces a result. The user must write the expected value register
// through the cfg channel only while idle; the block does not enforce this.
module key_hash_unlock_check import khuc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  khuc_in_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output khuc_out_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic      in_valid_q;
  khuc_in_t  in_q;
  logic      hash_ready;
  logic      fin_valid;
  khuc_fin_t fin_data;
  logic      lock_ready;
  logic      in_fire;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = in_valid_q && !hash_ready;
  assign in_fire     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      in_q <= in_data_i;
    end
  end

  khuc_hash u_hash (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .up_valid_i (in_valid_q),
    .up_data_i  (in_q),
    .up_ready_o (hash_ready),
    .dn_valid_o (fin_valid),
    .dn_data_o  (fin_data),
    .dn_ready_i (lock_ready)
  );

  khuc_lock u_lock (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .up_valid_i  (fin_valid),
    .up_data_i   (fin_data),
    .up_ready_o  (lock_ready),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule

// ===== sv/khuc_hash.sv =====
// ----------------------------------------------------------------------------
// khuc_hash
// Hash stage: absorbs one key byte per cycle, unless the lock stage holds it,
// into the running hash and registers the finished hash or the lock command.
// ----------------------------------------------------------------------------
module khuc_hash import khuc_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      up_valid_i,
  input  khuc_in_t  up_data_i,
  output logic      up_ready_o,
  output logic      dn_valid_o,
  output khuc_fin_t dn_data_o,
  input  logic      dn_ready_i
);

  logic        res_valid_q, res_valid_d;
  khuc_fin_t   res_q, res_d;
  logic [31:0] hash_q, hash_d;
  logic [1:0]  kind_q, kind_d;
  logic        odd_q, odd_d;
  logic        start_q, start_d;

  logic        fire;
  logic [31:0] byte_ext;
  logic [1:0]  kind_cur;
  logic [31:0] hash_cur;
  logic        odd_cur;
  logic [31:0] prod;
  logic [31:0] hash_new;

  assign up_ready_o = !res_valid_q || dn_ready_i;
  assign fire       = up_valid_i && up_ready_o;
  assign dn_valid_o = res_valid_q;
  assign dn_data_o  = res_q;

  assign byte_ext = {{24{up_data_i.key_byte[7]}}, up_data_i.key_byte};

  // First byte of a key picks the hash and its seed
  always_comb begin
    kind_cur = kind_q;
    hash_cur = hash_q;
    odd_cur  = odd_q;
    if (start_q) begin
      odd_cur  = 1'b0;
      hash_cur = '0;
      if (up_data_i.key_byte >= AP_CHAR_LO && up_data_i.key_byte <= AP_CHAR_HI) begin
        kind_cur = KIND_AP;
        hash_cur = AP_SEED;
      end else if (up_data_i.key_byte > AP_CHAR_HI &&
                   up_data_i.key_byte <= BP_CHAR_HI) begin
        kind_cur = KIND_BP;
      end else begin
        kind_cur = KIND_MX;
      end
    end
  end

  assign prod = hash_cur * MX_FACTOR;

  always_comb begin
    case (kind_cur)
      KIND_AP: begin
        if (!odd_cur) begin
          hash_new = hash_cur ^ ((hash_cur << 7) ^ byte_ext ^ (hash_cur >> 3));
        end else begin
          hash_new = hash_cur ^ ~((hash_cur << 11) ^ byte_ext ^ (hash_cur >> 5));
        end
      end
      KIND_BP: begin
        hash_new = (hash_cur << 7) ^ byte_ext;
      end
      default: begin
        hash_new = prod ^ byte_ext;
      end
    endcase
  end

  always_comb begin
    res_valid_d = res_valid_q && !dn_ready_i;
    res_d       = res_q;
    hash_d      = hash_q;
    kind_d      = kind_q;
    odd_d       = odd_q;
    start_d     = start_q;
    if (fire) begin
      if (up_data_i.op == OP_LOCK) begin
        res_valid_d   = 1'b1;
        res_d.is_lock = 1'b1;
        res_d.hash    = '0;
        hash_d        = '0;
        odd_d         = 1'b0;
        start_d       = 1'b1;
      end else if (up_data_i.last) begin
        res_valid_d   = 1'b1;
        res_d.is_lock = 1'b0;
        res_d.hash    = hash_new;
        kind_d        = kind_cur;
        hash_d        = '0;
        odd_d         = 1'b0;
        start_d       = 1'b1;
      end else begin
        kind_d  = kind_cur;
        hash_d  = hash_new;
        odd_d   = !odd_cur;
        start_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
      hash_q      <= '0;
      kind_q      <= KIND_AP;
      odd_q       <= 1'b0;
      start_q     <= 1'b1;
    end else begin
      res_valid_q <= res_valid_d;
      hash_q      <= hash_d;
      kind_q      <= kind_d;
      odd_q       <= odd_d;
      start_q     <= start_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  a_lock_restarts_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && up_data_i.op == OP_LOCK) |=> (start_q && hash_q == '0 && !odd_q))
    else $error("lock command did not restart the key");

  a_result_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (up_data_i.op == OP_LOCK || up_data_i.last)) |=> res_valid_q)
    else $error("finished key or lock gave no result");

  a_no_result_mid_key: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && up_data_i.op == OP_KEY_BYTE && !up_data_i.last) |=> !start_q)
    else $error("middle key byte ended the key");

endmodule

// ===== sv/khuc_lock.sv =====
// ----------------------------------------------------------------------------
// khuc_lock
// Lock stage: compares the finished hash with the expected value, keeps the
// lock flag and holds the result register.
// ----------------------------------------------------------------------------
module khuc_lock import khuc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [31:0] cfg_data_i,
  input  logic        up_valid_i,
  input  khuc_fin_t   up_data_i,
  output logic        up_ready_o,
  output logic        out_valid_o,
  output khuc_out_t   out_data_o,
  input  logic        out_stall_i
);

  logic        expected_q;
  logic [31:0] exp_val_q;
  logic        lock_q, lock_d;
  logic        out_valid_q, out_valid_d;
  khuc_out_t   out_q, out_d;
  logic        fire;
  logic        hit;

  assign up_ready_o  = !out_valid_q || !out_stall_i;
  assign fire        = up_valid_i && up_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  assign hit = (up_data_i.hash == exp_val_q);

  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    lock_d      = lock_q;
    if (fire) begin
      out_valid_d = 1'b1;
      if (up_data_i.is_lock) begin
        lock_d           = 1'b1;
        out_d.matched    = 1'b0;
        out_d.locked_now = 1'b1;
        out_d.hash_value = '0;
      end else begin
        if (hit) begin
          lock_d = 1'b0;
        end
        out_d.matched    = hit;
        out_d.locked_now = hit ? 1'b0 : lock_q;
        out_d.hash_value = up_data_i.hash;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q      <= 1'b1;
      out_valid_q <= 1'b0;
      exp_val_q   <= '0;
      expected_q  <= 1'b0;
    end else begin
      lock_q      <= lock_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        exp_val_q  <= cfg_data_i;
        expected_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  // expected_q only notes that software has written the register
  a_match_unlocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && !up_data_i.is_lock && hit) |=> (!lock_q && out_q.matched))
    else $error("matching key did not unlock");

  a_lock_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && up_data_i.is_lock) |=> (lock_q && out_valid_q && out_q.locked_now))
    else $error("lock command did not lock");

  a_flag_matches_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (out_q.locked_now == lock_q))
    else $error("reported lock flag differs from state");

  a_cfg_seen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> expected_q)
    else $error("configuration write lost");

endmodule

// ===== test/tb_key_hash_unlock_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_hash_unlock_check
// Self-checking bench for the key hash unlock check block.
// ----------------------------------------------------------------------------
// Keys are fed byte by byte while an in-bench model of the three hashes and
// of the lock flag predicts every result. The expected value register is set
// between phases, and each phase mixes matching keys, random keys, lock
// commands and abandoned keys under a different mix of sender gaps and
// receiver stalls.
module tb_key_hash_unlock_check;
  import khuc_pkg::*;

  typedef logic [7:0] key_q_t[$];

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned REPORT_MAX = 10;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid;
  logic        in_stall;
  khuc_in_t    in_data;
  logic        out_valid;
  logic        out_stall;
  khuc_out_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  key_hash_unlock_check uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  // predicted block state
  logic [31:0] acc_hash;
  logic [1:0]  acc_kind;
  logic        acc_odd;
  logic        fresh_key;
  logic        lock_state;
  logic [31:0] unlock_value;

  khuc_out_t   pending_results[$];

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned cycles;
  int unsigned n_requests;
  int unsigned n_results;
  int unsigned n_matches;
  int unsigned n_locks;
  int unsigned mismatches;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_stall = (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  function automatic logic [1:0] kind_of(logic [7:0] b);
    if (b >= AP_CHAR_LO && b <= AP_CHAR_HI) return KIND_AP;
    if (b > AP_CHAR_HI && b <= BP_CHAR_HI) return KIND_BP;
    return KIND_MX;
  endfunction

  function automatic logic [31:0] mix_byte(logic [31:0] h, logic [1:0] kind,
                                           logic odd, logic [7:0] b);
    logic [31:0] c;
    c = {{24{b[7]}}, b};
    case (kind)
      KIND_AP: begin
        if (odd) return h ^ ~((h << 11) ^ c ^ (h >> 5));
        return h ^ ((h << 7) ^ c ^ (h >> 3));
      end
      KIND_BP: return (h << 7) ^ c;
      default: return (h * MX_FACTOR) ^ c;
    endcase
  endfunction

  function automatic logic [31:0] key_hash(key_q_t k);
    logic [1:0]  kind;
    logic [31:0] h;
    kind = kind_of(k[0]);
    h = (kind == KIND_AP) ? AP_SEED : 32'h0;
    foreach (k[i]) h = mix_byte(h, kind, i[0], k[i]);
    return h;
  endfunction

  // queue one predicted result behind the ones already waiting
  function automatic void expect_result(khuc_out_t res);
    pending_results = {pending_results, res};
  endfunction

  // advance the predicted state by one accepted request
  function automatic void predict_request(khuc_in_t req);
    khuc_out_t res;
    if (req.op == OP_LOCK) begin
      lock_state = 1'b1;
      fresh_key = 1'b1;
      res.matched = 1'b0;
      res.locked_now = 1'b1;
      res.hash_value = 32'h0;
      expect_result(res);
      n_locks++;
      return;
    end
    if (fresh_key) begin
      acc_kind = kind_of(req.key_byte);
      acc_hash = (acc_kind == KIND_AP) ? AP_SEED : 32'h0;
      acc_odd = 1'b0;
      fresh_key = 1'b0;
    end
    acc_hash = mix_byte(acc_hash, acc_kind, acc_odd, req.key_byte);
    acc_odd = ~acc_odd;
    if (!req.last) return;
    res.matched = (acc_hash == unlock_value);
    if (res.matched) begin
      lock_state = 1'b0;
      n_matches++;
    end
    res.locked_now = lock_state;
    res.hash_value = acc_hash;
    expect_result(res);
    fresh_key = 1'b1;
  endfunction

  always @(posedge clk_i) begin
    khuc_out_t want;
    if (rst_ni && out_valid && !out_stall) begin
      n_results++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Unexpected result: matched=%0b locked=%0b hash=%08h",
                   out_data.matched, out_data.locked_now, out_data.hash_value);
      end else begin
        want = pending_results.pop_front();
        if (out_data.matched !== want.matched ||
            out_data.locked_now !== want.locked_now ||
            out_data.hash_value !== want.hash_value) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("Mismatch on result %0d: expected m=%0b l=%0b h=%08h, got m=%0b l=%0b h=%08h",
                     n_results, want.matched, want.locked_now, want.hash_value,
                     out_data.matched, out_data.locked_now, out_data.hash_value);
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge
  task automatic send_request(khuc_in_t req);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      in_data = khuc_in_t'($urandom);
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    in_data = req;
    do @(posedge clk_i); while (in_stall);
    predict_request(req);
    n_requests++;
    @(negedge clk_i);
  endtask

  task automatic send_key(key_q_t k, bit terminate = 1'b1);
    khuc_in_t req;
    foreach (k[i]) begin
      req.op = OP_KEY_BYTE;
      req.key_byte = k[i];
      req.last = terminate && (i == k.size() - 1);
      send_request(req);
    end
  endtask

  task automatic send_lock();
    khuc_in_t req;
    req.op = OP_LOCK;
    req.key_byte = 8'($urandom);
    req.last = 1'($urandom);
    send_request(req);
  endtask

  // wait for every result, then let any trailing key bytes clear the pipe
  task automatic wait_idle();
    in_valid = 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_unlock_value(logic [31:0] value);
    wait_idle();
    cfg_valid = 1'b1;
    cfg_data = value;
    do @(posedge clk_i); while (!cfg_ready);
    unlock_value = value;
    @(negedge clk_i);
    cfg_valid = 1'b0;
    cfg_data = 32'h0;
  endtask

  function automatic key_q_t random_key(int unsigned len);
    key_q_t k;
    logic [7:0] b;
    case ($urandom_range(2))
      0: b = 8'($urandom_range(AP_CHAR_LO, AP_CHAR_HI));
      1: b = 8'($urandom_range(AP_CHAR_HI + 1, BP_CHAR_HI));
      default: begin
        do b = 8'($urandom); while (b >= AP_CHAR_LO && b <= BP_CHAR_HI);
      end
    endcase
    k = {k, b};
    repeat (len - 1) k = {k, 8'($urandom)};
    return k;
  endfunction

  // reset value of the register is 0, and a lone zero byte hashes to 0
  task automatic test_after_reset();
    send_lock();
    send_key('{8'h00});
    send_lock();
  endtask

  task automatic test_hash_selection();
    key_q_t edges;
    edges = '{8'h2F, 8'h30, 8'h4D, 8'h4E, 8'h6D, 8'h6E, 8'h80, 8'hFF};
    foreach (edges[i]) send_key('{edges[i]});
    send_key('{8'h30, 8'h4D, 8'hF0});  // AP with even and odd positions
  endtask

  task automatic test_unlock_sequence();
    key_q_t good;
    good = '{8'h41, 8'h5A};
    write_unlock_value(key_hash(good));
    send_key(good);              // unlocks
    send_key(good);              // match while already unlocked
    send_key('{8'h4E});          // mismatch keeps it unlocked
    send_key('{8'h4E}, 1'b0);    // abandoned by the lock request
    send_lock();
    send_key(good);
  endtask

  task automatic test_random_traffic(int unsigned n, int unsigned idle_pct,
                                     int unsigned stall_pct, key_q_t unlock_key);
    int unsigned start;
    int unsigned pick;
    int unsigned len;
    write_unlock_value(key_hash(unlock_key));
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    start = n_requests;
    while (n_requests - start < n) begin
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? $urandom_range(9, 32) : $urandom_range(1, 8);
      if (pick < 12) begin
        send_key(unlock_key);
      end else if (pick < 20) begin
        send_lock();
      end else if (pick < 28) begin
        send_key(random_key($urandom_range(1, 4)), 1'b0);
        send_lock();
      end else begin
        send_key(random_key(len));
      end
    end
    in_valid = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    key_q_t secret;
    clk_i = 1'b0;
    rst_ni = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_data = 32'h0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    acc_hash = 32'h0;
    acc_kind = KIND_AP;
    acc_odd = 1'b0;
    fresh_key = 1'b1;
    lock_state = 1'b1;
    unlock_value = 32'h0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_after_reset();
    test_hash_selection();
    test_unlock_sequence();

    secret = random_key($urandom_range(1, 6));
    test_random_traffic(380, 0, 0, secret);
    test_random_traffic(380, 86, 0, '{8'h00});        // unlock value 0
    test_random_traffic(380, 0, 86, '{8'hFF});        // unlock value all ones
    secret = random_key($urandom_range(1, 6));
    test_random_traffic(380, 26, 26, secret);

    wait_idle();
    if (pending_results.size() != 0) mismatches++;

    $display("Sent %0d requests (%0d lock commands), checked %0d results, %0d unlocking matches",
             n_requests, n_locks, n_results, n_matches);
    $display("Traffic ran with no gaps, sender gaps, receiver stalls and both; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
